/* hdl/cst_pkg.sv */
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types, character codes and decode functions for the character
// stream tokenizer.
// ----------------------------------------------------------------------------
package cst_pkg;

  // Default parameter values
  localparam int NAME_BUFFER_DEF = 128;
  localparam int POS_WIDTH_DEF   = 16;

  // Fixed field widths of a result transaction
  localparam int POS_OUT_W = 16;
  localparam int LEN_W     = 7;
  localparam int VALUE_W   = 32;

  // Result queue depth (room for two transactions per accepted character)
  localparam int QDEPTH = 4;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;

  // Token kinds
  typedef enum logic [3:0] {
    K_INT    = 4'd0,
    K_NAME   = 4'd1,
    K_LPAREN = 4'd2,
    K_RPAREN = 4'd3,
    K_STAR   = 4'd4,
    K_PLUS   = 4'd5,
    K_MINUS  = 4'd6,
    K_SEMI   = 4'd7,
    K_EQ     = 4'd8,
    K_LBRACE = 4'd9,
    K_RBRACE = 4'd10,
    K_EOF    = 4'd11,
    K_CTRL   = 4'd12,
    K_BAD    = 4'd13,
    K_LONG   = 4'd14
  } kind_t;

  // One result transaction
  typedef struct packed {
    kind_t                kind;
    logic [VALUE_W-1:0]   value;
    logic [POS_OUT_W-1:0] line;
    logic [POS_OUT_W-1:0] column;
    logic [LEN_W-1:0]     length;
    logic                 last;
  } tok_t;

  // Results produced by one accepted character
  typedef struct packed {
    logic [1:0] n;
    tok_t       t0;
    tok_t       t1;
  } push_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_name_char(input logic [7:0] c);
    return (c == CH_UNDER) || is_digit(c) || ((c >= CH_UA) && (c <= CH_UZ)) ||
           ((c >= CH_LA) && (c <= CH_LZ));
  endfunction

  function automatic logic is_hex_digit(input logic [7:0] c);
    return is_digit(c) || ((c >= CH_UA) && (c <= CH_UF));
  endfunction

  // Digit value; only meaningful when is_hex_digit() holds
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    d = is_digit(c) ? (c - CH_0) : (c - CH_UA + 8'd10);
    return d[3:0];
  endfunction

  function automatic kind_t punct_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      CH_LPAR:  k = K_LPAREN;
      CH_RPAR:  k = K_RPAREN;
      CH_STAR:  k = K_STAR;
      CH_PLUS:  k = K_PLUS;
      CH_MINUS: k = K_MINUS;
      CH_SEMI:  k = K_SEMI;
      CH_EQ:    k = K_EQ;
      CH_LBRC:  k = K_LBRACE;
      CH_RBRC:  k = K_RBRACE;
      default:  k = K_BAD;
    endcase
    return k;
  endfunction

endpackage

/* hdl/cst_core.sv */
// ----------------------------------------------------------------------------
// cst_core
// Per-character scanner: position tracking, word accumulation, integer
// conversion and token formation. Produces up to two results per character.
// ----------------------------------------------------------------------------
module cst_core #(
  parameter int NAME_BUFFER = cst_pkg::NAME_BUFFER_DEF,
  parameter int POS_WIDTH   = cst_pkg::POS_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  logic [7:0]     char_code,
  output cst_pkg::push_t push
);
  import cst_pkg::*;

  localparam int CNT_W = $clog2(NAME_BUFFER);
  localparam logic [CNT_W-1:0]     MAX_WORD = CNT_W'(NAME_BUFFER - 1);
  localparam logic [POS_WIDTH-1:0] POS_MAX  = '1;

  // Scanner state
  logic                 in_word, in_word_next;
  logic [VALUE_W-1:0]   word_value, word_value_next;
  logic                 word_is_number, word_is_number_next;
  logic                 hex_seen, hex_seen_next;
  logic [CNT_W-1:0]     word_count, word_count_next;
  logic                 discarding_word, discarding_word_next;
  logic                 first_char_pending, first_char_pending_next;
  logic [POS_WIDTH-1:0] cur_line, cur_line_next;
  logic [POS_WIDTH-1:0] cur_column, cur_column_next;
  logic [POS_WIDTH-1:0] start_line, start_line_next;
  logic [POS_WIDTH-1:0] start_column, start_column_next;

  // Advanced position of this character
  logic [POS_WIDTH-1:0] line_adv, col_adv;

  // Position and length resized to the result field widths
  logic [POS_WIDTH+POS_OUT_W-1:0] sl_ext, sc_ext, la_ext, ca_ext;
  logic [CNT_W+LEN_W-1:0]         cnt_ext;

  logic               is_name;
  logic [3:0]         dec_digit;
  logic [VALUE_W-1:0] mul10;
  logic               a_valid, b_valid;
  tok_t               tok_a, tok_b;

  assign sl_ext  = {{POS_OUT_W{1'b0}}, start_line};
  assign sc_ext  = {{POS_OUT_W{1'b0}}, start_column};
  assign la_ext  = {{POS_OUT_W{1'b0}}, line_adv};
  assign ca_ext  = {{POS_OUT_W{1'b0}}, col_adv};
  assign cnt_ext = {{LEN_W{1'b0}}, word_count};

  assign is_name   = is_name_char(char_code);
  assign dec_digit = hex_value(char_code);
  // value * 10 + digit as shift-and-add, wrapping at 32 bits
  assign mul10 = {word_value[VALUE_W-4:0], 3'b000} + {word_value[VALUE_W-2:0], 1'b0} +
                 {{(VALUE_W-4){1'b0}}, dec_digit};

  // Position advance, saturating
  always_comb begin
    line_adv = cur_line;
    col_adv  = cur_column;
    if (!first_char_pending) begin
      if (char_code == CH_LF) begin
        line_adv = (cur_line == POS_MAX) ? cur_line : cur_line + POS_WIDTH'(1);
        col_adv  = '0;
      end else begin
        col_adv = (cur_column == POS_MAX) ? cur_column : cur_column + POS_WIDTH'(1);
      end
    end
  end

  // Scanner next state and token formation
  always_comb begin
    in_word_next            = in_word;
    word_value_next         = word_value;
    word_is_number_next     = word_is_number;
    hex_seen_next           = hex_seen;
    word_count_next         = word_count;
    discarding_word_next    = discarding_word;
    first_char_pending_next = 1'b0;
    cur_line_next           = line_adv;
    cur_column_next         = col_adv;
    start_line_next         = start_line;
    start_column_next       = start_column;

    // slot A: word end or too-long, at the word start
    a_valid       = 1'b0;
    tok_a.kind    = K_NAME;
    tok_a.value   = '0;
    tok_a.line    = sl_ext[POS_OUT_W-1:0];
    tok_a.column  = sc_ext[POS_OUT_W-1:0];
    tok_a.length  = cnt_ext[LEN_W-1:0];
    tok_a.last    = 1'b0;
    // slot B: token of this character itself
    b_valid       = 1'b0;
    tok_b.kind    = K_BAD;
    tok_b.value   = '0;
    tok_b.line    = la_ext[POS_OUT_W-1:0];
    tok_b.column  = ca_ext[POS_OUT_W-1:0];
    tok_b.length  = LEN_W'(1);
    tok_b.last    = 1'b1;

    if (in_word && is_name) begin
      // word continues
      if (!discarding_word) begin
        if (word_count >= MAX_WORD) begin
          discarding_word_next = 1'b1;
          a_valid              = 1'b1;
          tok_a.kind           = K_LONG;
          tok_a.length         = '0;
        end else begin
          word_count_next = word_count + CNT_W'(1);
          if (word_is_number) begin
            if (hex_seen) begin
              if (is_hex_digit(char_code)) begin
                word_value_next = {word_value[VALUE_W-5:0], dec_digit};
              end else begin
                word_is_number_next = 1'b0;
              end
            end else if (is_digit(char_code)) begin
              word_value_next = mul10;
            end else if (char_code == CH_X) begin
              hex_seen_next   = 1'b1;
              word_value_next = '0;
            end else begin
              word_is_number_next = 1'b0;
            end
          end
        end
      end
    end else begin
      // close any open word
      if (in_word) begin
        a_valid     = !discarding_word;
        tok_a.kind  = word_is_number ? K_INT : K_NAME;
        tok_a.value = word_is_number ? word_value : '0;
        in_word_next         = 1'b0;
        word_value_next      = '0;
        word_is_number_next  = 1'b0;
        hex_seen_next        = 1'b0;
        word_count_next      = '0;
        discarding_word_next = 1'b0;
      end

      // classify this character
      if ((char_code == CH_SPACE) || (char_code == CH_TAB) ||
          (char_code == CH_CR) || (char_code == CH_LF)) begin
        b_valid = 1'b0;
      end else if (char_code == CH_NUL) begin
        b_valid                 = 1'b1;
        tok_b.kind              = K_EOF;
        tok_b.length            = '0;
        first_char_pending_next = 1'b1;
        cur_line_next           = '0;
        cur_column_next         = '0;
      end else if (char_code < CH_SPACE) begin
        b_valid    = 1'b1;
        tok_b.kind = K_CTRL;
      end else if (is_name) begin
        in_word_next         = 1'b1;
        word_count_next      = CNT_W'(1);
        start_line_next      = line_adv;
        start_column_next    = col_adv;
        word_is_number_next  = is_digit(char_code);
        word_value_next      = is_digit(char_code) ? {{(VALUE_W-4){1'b0}}, dec_digit} : '0;
        hex_seen_next        = 1'b0;
        discarding_word_next = 1'b0;
      end else begin
        b_valid    = 1'b1;
        tok_b.kind = punct_kind(char_code);
      end
    end

    // pack results in order
    tok_a.last = !b_valid;
    push.n  = fire ? ({1'b0, a_valid} + {1'b0, b_valid}) : 2'd0;
    push.t0 = a_valid ? tok_a : tok_b;
    push.t1 = tok_b;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_word            <= 1'b0;
      word_value         <= '0;
      word_is_number     <= 1'b0;
      hex_seen           <= 1'b0;
      word_count         <= '0;
      discarding_word    <= 1'b0;
      first_char_pending <= 1'b1;
      cur_line           <= '0;
      cur_column         <= '0;
      start_line         <= '0;
      start_column       <= '0;
    end else if (fire) begin
      in_word            <= in_word_next;
      word_value         <= word_value_next;
      word_is_number     <= word_is_number_next;
      hex_seen           <= hex_seen_next;
      word_count         <= word_count_next;
      discarding_word    <= discarding_word_next;
      first_char_pending <= first_char_pending_next;
      cur_line           <= cur_line_next;
      cur_column         <= cur_column_next;
      start_line         <= start_line_next;
      start_column       <= start_column_next;
    end
  end

endmodule

/* hdl/cst_outq.sv */
// ----------------------------------------------------------------------------
// cst_outq
// Result queue: takes zero, one or two results per cycle and hands them out
// one transaction at a time. Ready while room for two remains.
// ----------------------------------------------------------------------------
module cst_outq (
  input  logic           clk,
  input  logic           rst,
  input  cst_pkg::push_t push,
  input  logic           pop,
  output logic           ready,
  output logic           head_valid,
  output cst_pkg::tok_t  head
);
  import cst_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  tok_t             mem [QDEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;
  logic             pop_ok;

  assign head_valid = (count != '0);
  assign pop_ok     = pop && head_valid;
  assign ready      = (count <= CNT_W'(QDEPTH - 2));
  assign head       = mem[rptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wptr] <= push.t0;
    end
    if (push.n == 2'd2) begin
      mem[wptr + PTR_W'(1)] <= push.t1;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + PTR_W'(push.n);
      rptr  <= rptr + PTR_W'(pop_ok);
      count <= count + CNT_W'(push.n) - CNT_W'(pop_ok);
    end
  end

endmodule

/* hdl/char_stream_tokenizer.sv */
// ----------------------------------------------------------------------------
// char_stream_tokenizer
// Character stream tokenizer, top level.
// ----------------------------------------------------------------------------
// Takes one text byte per transaction and emits tokens (integer, name,
// punctuation, end of text, control, bad character, too long) with their
// starting line and column. A character offered while char_stall is low is taken in
// that cycle and its results are registered in a four-entry result queue, so the input
// runs at one character per cycle as long as tokens drain at least as fast
// as they are made; a character that closes a word and is a token itself
// yields two output transactions, and char_stall rises only when the queue
// holds more than two results.
// ----------------------------------------------------------------------------
module char_stream_tokenizer #(
  parameter int NAME_BUFFER = cst_pkg::NAME_BUFFER_DEF,
  parameter int POS_WIDTH   = cst_pkg::POS_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                char_valid,
  output logic                                char_stall,
  input  logic [7:0]                          char_code,
  output logic                                token_valid,
  input  logic                                token_stall,
  output logic [3:0]                          token_kind,
  output logic signed [cst_pkg::VALUE_W-1:0]  token_value,
  output logic [cst_pkg::POS_OUT_W-1:0]       token_line,
  output logic [cst_pkg::POS_OUT_W-1:0]       token_column,
  output logic [cst_pkg::LEN_W-1:0]           token_length,
  output logic                                last_of_run
);
  import cst_pkg::*;

  logic  fire;
  logic  ready;
  push_t push;
  tok_t  head;

  assign char_stall = !ready;
  assign fire       = char_valid && !char_stall;

  // Scanner
  cst_core #(
    .NAME_BUFFER (NAME_BUFFER),
    .POS_WIDTH   (POS_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .char_code (char_code),
    .push      (push)
  );

  // Result queue
  cst_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (!token_stall),
    .ready      (ready),
    .head_valid (token_valid),
    .head       (head)
  );

  // Output fields
  assign token_kind   = head.kind;
  assign token_value  = $signed(head.value);
  assign token_line   = head.line;
  assign token_column = head.column;
  assign token_length = head.length;
  assign last_of_run  = head.last;

`ifndef NO_ASSERTIONS
  // A character that makes tokens shows one on the next cycle
  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    (fire && (push.n != 2'd0)) |=> token_valid)
    else $error("result not visible after push");

  // Input is held off only while results are waiting
  a_stall_has_data: assert property (@(posedge clk) disable iff (rst)
    char_stall |-> token_valid)
    else $error("input stalled with empty result queue");

  // End of text and too-long tokens always close a character's run
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    (token_valid && ((token_kind == K_EOF) || (token_kind == K_LONG))) |-> last_of_run)
    else $error("eof or too-long token not marked last");

  // Only integer tokens carry a value
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    (token_valid && (token_kind != K_INT)) |-> (token_value == '0))
    else $error("non-integer token with nonzero value");
`endif

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for char_stream_tokenizer.
// ----------------------------------------------------------------------------
// A queue of text bytes feeds a clocked driver. Each byte the block takes is
// run through a tokenizer predictor here, which queues the tokens it should
// produce. A clocked monitor checks every token the block hands out against
// the oldest queued token, field by field. The text is a short directed
// opening, then random token-shaped text (numbers, hex, names, punctuation,
// whitespace, control and arbitrary bytes, end of text, overlong words)
// under three stall mixes.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cst_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int WORD_LIMIT = NAME_BUFFER_DEF - 1;
  localparam logic [POS_OUT_W-1:0] POS_LIMIT = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic char_valid = 1'b0;
  logic char_stall;
  logic [7:0] char_code = '0;
  logic token_valid;
  logic token_stall = 1'b0;
  logic [3:0] token_kind;
  logic signed [VALUE_W-1:0] token_value;
  logic [POS_OUT_W-1:0] token_line;
  logic [POS_OUT_W-1:0] token_column;
  logic [LEN_W-1:0] token_length;
  logic last_of_run;

  char_stream_tokenizer dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_code    (char_code),
    .token_valid  (token_valid),
    .token_stall  (token_stall),
    .token_kind   (token_kind),
    .token_value  (token_value),
    .token_line   (token_line),
    .token_column (token_column),
    .token_length (token_length),
    .last_of_run  (last_of_run)
  );

  // Text bytes waiting to be sent, and tokens still owed by the block
  logic [7:0] text_bytes[$];
  tok_t pending_tokens[$];

  int chars_queued = 0;
  int chars_sent = 0;
  int tokens_checked = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int kind_hits[16];

  // Tokenizer state as the predictor sees it
  bit word_open = 1'b0;
  bit word_numeric = 1'b0;
  bit word_hex = 1'b0;
  bit word_dropping = 1'b0;
  bit text_start = 1'b1;
  logic [31:0] word_acc = '0;
  logic [LEN_W-1:0] word_len = '0;
  logic [POS_OUT_W-1:0] line_pos = '0;
  logic [POS_OUT_W-1:0] col_pos = '0;
  logic [POS_OUT_W-1:0] word_line = '0;
  logic [POS_OUT_W-1:0] word_col = '0;

  logic [7:0] punct_set[9] = '{CH_LPAR, CH_RPAR, CH_STAR, CH_PLUS, CH_MINUS,
                               CH_SEMI, CH_EQ, CH_LBRC, CH_RBRC};
  logic [7:0] blank_set[4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};

  // Opening text: every punctuation mark, word closed by punctuation and by
  // a control byte, hex number, whitespace kinds, byte extremes, end of text
  logic [7:0] opening_text[27] = '{8'h01, CH_LPAR, "z", CH_RPAR, CH_STAR,
                                   CH_PLUS, CH_MINUS, CH_SEMI, CH_EQ, CH_LBRC,
                                   CH_RBRC, CH_TAB, "9", CH_CR, CH_LF, "0",
                                   CH_X, "F", "F", 8'h1F, 8'h7F, 8'h80, 8'hFF,
                                   "Z", CH_UNDER, CH_SPACE, CH_NUL};

  function automatic bit is_word_char(logic [7:0] c);
    return c == CH_UNDER || (c >= CH_0 && c <= CH_9) ||
           (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ);
  endfunction

  function automatic tok_t make_token(kind_t k, logic [31:0] v, logic [15:0] ln,
                                      logic [15:0] col, logic [6:0] len);
    tok_t t;
    t.kind = k;
    t.value = v;
    t.line = ln;
    t.column = col;
    t.length = len;
    t.last = 1'b0;
    return t;
  endfunction

  // Advance the tokenizer by one byte and queue the tokens it yields
  task automatic tokenize_char(input logic [7:0] c);
    tok_t found[2];
    int n;
    kind_t k;
    bit has_own;
    bit wordy;
    bit digit;
    n = 0;
    k = K_BAD;
    has_own = 1'b1;
    wordy = is_word_char(c);
    digit = (c >= CH_0 && c <= CH_9);

    // position of this byte; first byte of a text sits at the origin
    if (text_start) begin
      text_start = 1'b0;
    end else if (c == CH_LF) begin
      if (line_pos != POS_LIMIT) line_pos++;
      col_pos = '0;
    end else if (col_pos != POS_LIMIT) begin
      col_pos++;
    end

    if (word_open && wordy) begin
      // word continues: count it, feed the number conversion
      if (!word_dropping) begin
        if (word_len >= WORD_LIMIT) begin
          word_dropping = 1'b1;
          found[n] = make_token(K_LONG, '0, word_line, word_col, '0);
          n++;
        end else begin
          word_len++;
          if (word_numeric) begin
            if (word_hex) begin
              if (digit)
                word_acc = word_acc * 32'd16 + 32'(c - CH_0);
              else if (c >= CH_UA && c <= CH_UF)
                word_acc = word_acc * 32'd16 + 32'(c - CH_UA) + 32'd10;
              else
                word_numeric = 1'b0;
            end else if (digit) begin
              word_acc = word_acc * 32'd10 + 32'(c - CH_0);
            end else if (c == CH_X) begin
              word_hex = 1'b1;
              word_acc = '0;
            end else begin
              word_numeric = 1'b0;
            end
          end
        end
      end
    end else begin
      // any open word ends ahead of this byte's own token
      if (word_open) begin
        if (!word_dropping) begin
          found[n] = make_token(word_numeric ? K_INT : K_NAME,
                                word_numeric ? word_acc : '0,
                                word_line, word_col, word_len);
          n++;
        end
        word_open = 1'b0;
        word_dropping = 1'b0;
      end

      if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
        has_own = 1'b0;
      end else if (c == CH_NUL) begin
        found[n] = make_token(K_EOF, '0, line_pos, col_pos, '0);
        n++;
        text_start = 1'b1;
        line_pos = '0;
        col_pos = '0;
        has_own = 1'b0;
      end else if (c < CH_SPACE) begin
        k = K_CTRL;
      end else if (wordy) begin
        word_open = 1'b1;
        word_len = 7'd1;
        word_line = line_pos;
        word_col = col_pos;
        word_numeric = digit;
        word_acc = digit ? 32'(c - CH_0) : '0;
        word_hex = 1'b0;
        word_dropping = 1'b0;
        has_own = 1'b0;
      end else begin
        case (c)
          CH_LPAR:  k = K_LPAREN;
          CH_RPAR:  k = K_RPAREN;
          CH_STAR:  k = K_STAR;
          CH_PLUS:  k = K_PLUS;
          CH_MINUS: k = K_MINUS;
          CH_SEMI:  k = K_SEMI;
          CH_EQ:    k = K_EQ;
          CH_LBRC:  k = K_LBRACE;
          CH_RBRC:  k = K_RBRACE;
          default:  k = K_BAD;
        endcase
      end
      if (has_own) begin
        found[n] = make_token(k, '0, line_pos, col_pos, 7'd1);
        n++;
      end
    end

    if (n > 0) found[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_tokens.push_back(found[i]);
  endtask

  // ---------------------------------------------------------------- text gen
  task automatic queue_char(input logic [7:0] c);
    text_bytes.push_back(c);
    chars_queued++;
  endtask

  function automatic logic [7:0] rand_word_char();
    int r;
    r = $urandom_range(62);
    if (r < 10) return 8'(CH_0 + r);
    if (r < 36) return 8'(CH_UA + r - 10);
    if (r < 62) return 8'(CH_LA + r - 36);
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int r;
    r = $urandom_range(15);
    return (r < 10) ? 8'(CH_0 + r) : 8'(CH_UA + r - 10);
  endfunction

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(52);
    if (r < 26) return 8'(CH_UA + r);
    if (r < 52) return 8'(CH_LA + r - 26);
    return CH_UNDER;
  endfunction

  task automatic queue_digits(input int count);
    repeat (count) queue_char(8'(CH_0 + $urandom_range(9)));
  endtask

  // Usually end a word with whitespace or punctuation; sometimes let it run on
  task automatic close_word();
    if ($urandom_range(99) < 85) begin
      if ($urandom_range(1) == 0) queue_char(blank_set[$urandom_range(3)]);
      else queue_char(punct_set[$urandom_range(8)]);
    end
  endtask

  // Random token-shaped text, with one word of long_len bytes midway
  task automatic queue_text(input int budget, input int long_len);
    int first;
    int pick;
    bit long_done;
    bit numeric;
    first = chars_queued;
    long_done = 1'b0;
    while (chars_queued - first < budget) begin
      if (!long_done && chars_queued - first >= budget / 2) begin
        numeric = $urandom_range(1);
        if (numeric) queue_digits(long_len);
        else begin
          queue_char(rand_letter());
          repeat (long_len - 1) queue_char(rand_word_char());
        end
        close_word();
        long_done = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 22) begin
        // decimal, long enough at times to wrap
        queue_digits($urandom_range(1, 12));
        close_word();
      end else if (pick < 34) begin
        // hex after a lowercase x, now and then spoiled by a stray character
        queue_digits($urandom_range(1, 2));
        queue_char(CH_X);
        repeat ($urandom_range(0, 9)) queue_char(rand_hex_char());
        if ($urandom_range(7) == 0) queue_char(rand_word_char());
        close_word();
      end else if (pick < 54) begin
        queue_char(rand_letter());
        repeat ($urandom_range(0, 9)) queue_char(rand_word_char());
        close_word();
      end else if (pick < 69) begin
        queue_char(punct_set[$urandom_range(8)]);
      end else if (pick < 79) begin
        queue_char(blank_set[$urandom_range(3)]);
      end else if (pick < 84) begin
        queue_char(8'($urandom_range(1, 31)));
      end else if (pick < 90) begin
        queue_char(8'($urandom_range(0, 255)));
      end else if (pick < 94) begin
        queue_char(CH_NUL);
      end else begin
        // digits followed by random word characters, which mostly fail the conversion
        queue_digits($urandom_range(1, 4));
        repeat ($urandom_range(1, 4)) queue_char(rand_word_char());
        close_word();
      end
    end
  endtask

  task automatic wait_idle();
    while (chars_sent != chars_queued || pending_tokens.size() != 0) @(posedge clk);
  endtask

  function automatic int field_diff(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      return 1;
    end
    return 0;
  endfunction

  // ---------------------------------------------------------------- clock/reset
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else begin
      if (char_valid && !char_stall) begin
        tokenize_char(char_code);
        chars_sent++;
      end
      // offer the next byte once the current one is gone
      if (!char_valid || !char_stall) begin
        if (text_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          char_valid <= 1'b1;
          char_code <= text_bytes.pop_front();
        end else begin
          char_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin : token_monitor
    tok_t want;
    if (rst) begin
      token_stall <= 1'b0;
    end else begin
      if (token_valid && !token_stall) begin
        tokens_checked++;
        kind_hits[token_kind]++;
        if (pending_tokens.size() == 0) begin
          $error("unexpected token: kind %0d line %0d column %0d",
                 token_kind, token_line, token_column);
          mismatches++;
        end else begin
          want = pending_tokens.pop_front();
          mismatches += field_diff("token_kind", want.kind, token_kind);
          mismatches += field_diff("token_value", want.value, token_value);
          mismatches += field_diff("token_line", want.line, token_line);
          mismatches += field_diff("token_column", want.column, token_column);
          mismatches += field_diff("token_length", want.length, token_length);
          mismatches += field_diff("last_of_run", want.last, last_of_run);
        end
      end
      token_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    if (rst || (char_valid && !char_stall) || (token_valid && !token_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin : stimulus
    int kinds_seen;

    // slow sender, slower receiver
    send_idle_pct = 36;
    recv_stall_pct = 68;
    foreach (opening_text[i]) queue_char(opening_text[i]);
    queue_text(330, WORD_LIMIT);
    wait_idle();

    // the other way round; word one byte past the limit
    send_idle_pct = 68;
    recv_stall_pct = 36;
    queue_text(340, WORD_LIMIT + 1);
    wait_idle();

    // full rate
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_text(340, $urandom_range(WORD_LIMIT + 2, 200));
    wait_idle();
    repeat (20) @(posedge clk);

    kinds_seen = 0;
    foreach (kind_hits[i]) if (kind_hits[i] > 0) kinds_seen++;
    $display("Sent %0d characters under three stall mixes", chars_sent);
    $display("Checked %0d tokens covering %0d of 15 token kinds", tokens_checked,
             kinds_seen);
    if (mismatches == 0 && pending_tokens.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* char_stream_tokenizer.f */
hdl/cst_pkg.sv
hdl/cst_core.sv
hdl/cst_outq.sv
hdl/char_stream_tokenizer.sv
sim/tb.sv
